// ----- rtl/cubic_bezier_polyline_sampler_unit_defines.svh -----
// Assertion macros shared by the curve sampler RTL.
`ifndef CUBIC_BEZIER_POLYLINE_SAMPLER_UNIT_DEFINES_SVH
`define CUBIC_BEZIER_POLYLINE_SAMPLER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CBPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define CBPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cbps_pkg.sv -----
// Types and fixed constants of the cubic Bezier curve sampler.
package cbps_pkg;

   localparam int PT_W        = 16;
   localparam int C1_W        = 17;
   localparam int C2_W        = 18;
   localparam int C3_W        = 19;
   localparam int NUM_W       = 44;
   // Difference numerators stay below 2^30 in magnitude for any STEPS up to 63.
   localparam int DVD_W       = 30;
   localparam int DIV_QB      = 24;
   localparam int QUO_W       = DIV_QB + 1;
   localparam int SEG_PTS     = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [PT_W-1:0] point_x;
      logic signed [PT_W-1:0] point_y;
      logic                   first_point;
   } req_type;

   typedef struct packed {
      logic signed [PT_W-1:0] curve_x;
      logic signed [PT_W-1:0] curve_y;
      logic                   segment_end;
   } rsp_type;

   typedef struct packed {
      logic signed [PT_W-1:0] x;
      logic signed [PT_W-1:0] y;
   } point_type;

   typedef point_type [SEG_PTS-1:0] segment_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_COEF,
      BK_NUM,
      BK_LOAD,
      BK_DIV,
      BK_RUN
   } back_state_type;

   typedef struct packed {
      logic pop;
      logic coef_en;
      logic num_en;
      logic start;
      logic load_diff;
      logic emit;
   } back_ctrl_type;

endpackage

// ----- rtl/cubic_bezier_polyline_sampler_unit.sv -----
// Top level of the cubic Bezier polyline sampler.
//
// Usage:
//  - Requests on req_* carry one control point each; a request is taken at a rising
//    clock edge with req_valid high and req_stall low. first_point restarts the
//    polyline. The first four points form a segment, each further three points the
//    next segment, which starts at the previous segment's last point.
//  - Each finished segment yields STEPS+1 samples on rsp_*, one per cycle unless
//    rsp_stall holds them, taken at an edge with rsp_valid high and rsp_stall low;
//    segment_end marks the sample at t equal to one.
//  - Flow: a finished segment waits in a two-entry queue; the sampler pops it,
//    forms the polynomial coefficients, then the difference numerators, starts the
//    reciprocal-multiply dividers that set up the forward differences, waits for
//    them and then steps out the STEPS+1 samples. Points keep being taken while the
//    sampler works on an earlier segment, until the queue is full.
//  - req_stall rises only while the segment queue is full.
//  - rsp_stall holds the output register; the sampler waits and the queue keeps
//    taking segments until it fills.
//  - Reset (synchronous, active high) empties the queue, drops any collected points
//    and any segment in progress, and clears rsp_valid.
module cubic_bezier_polyline_sampler_unit import cbps_pkg::*; #(
   parameter int STEPS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   segment_type      q_push_data, q_pop_data;

   // Collect points; push each completed segment.
   cbps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // Hold segments so point collection and sampling stall independently.
   cbps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Set up forward differences and advance one sample per free output slot.
   cbps_back #(.STEPS(STEPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .q_data    (q_pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/cbps_front.sv -----
// Front end: collects control points and forms complete segments.
module cbps_front import cbps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             q_push,
   output segment_type      q_data
);

   localparam int          HELD_ENTRIES = SEG_PTS - 1;
   localparam logic [1:0]  LAST_SLOT    = 2'(SEG_PTS - 1);

   point_type  store_ff [HELD_ENTRIES];
   point_type  store_in [HELD_ENTRIES];
   logic [1:0] points_held_ff, points_held_in;
   logic       accept;
   logic [1:0] slot;
   point_type  pt;

   assign pt        = '{x: req_data.point_x, y: req_data.point_y};
   assign req_stall = q_status.full;
   assign accept    = req_valid & ~req_stall;
   // A start mark or an empty store puts the point at the head of a new polyline.
   assign slot      = (req_data.first_point || points_held_ff == 2'd0) ? 2'd0 : points_held_ff;
   assign q_push    = accept && (slot == LAST_SLOT);

   always_comb begin
      q_data[SEG_PTS-1] = pt;
      for (int i = 0; i < HELD_ENTRIES; i++) begin
         q_data[i] = store_ff[i];
      end
   end

   always_comb begin
      store_in       = store_ff;
      points_held_in = points_held_ff;
      if (accept) begin
         if (q_push) begin
            // Carry the segment's last point over as the next segment's first.
            store_in[0]    = pt;
            points_held_in = 2'd1;
         end else begin
            store_in[slot]  = pt;
            points_held_in  = slot + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      if (reset) begin
         points_held_ff <= 2'd0;
      end else begin
         points_held_ff <= points_held_in;
      end
   end

endmodule

// ----- rtl/cbps_queue.sv -----
// Short segment queue between the front end and the sampler.
`include "cubic_bezier_polyline_sampler_unit_defines.svh"

module cbps_queue import cbps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  segment_type      push_data,
   input  logic             pop,
   output segment_type      pop_data,
   output queue_status_type status
);

   localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

   segment_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign pop_data     = mem_ff[rd_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `CBPS_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, push, count_ff != FULL_CNT, "segment pushed into a full queue")
   `CBPS_ASSERT_IMPLY(a_queue_no_underflow, clock, reset, pop, count_ff != '0, "segment popped from an empty queue")

endmodule

// ----- rtl/cbps_div.sv -----
// Reciprocal-multiply divider by the constant STEPS cubed, floor quotient and remainder.
module cbps_div import cbps_pkg::*; #(
   parameter  int STEPS = 16,
   localparam int DEN   = STEPS * STEPS * STEPS,
   localparam int RW    = $clog2(DEN + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   output logic                    done,
   output logic signed [QUO_W-1:0] quo,
   output logic        [RW-1:0]    rem
);

   // Rounded-up reciprocal; exact floor quotient for every magnitude below 2^DVD_W.
   localparam int             RL         = $clog2(DEN);
   localparam int             SH         = DVD_W + RL;
   localparam int             PW         = 2 * DVD_W + 1;
   localparam logic [63:0]    RECIP_FULL = ((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
   localparam logic [DVD_W:0] RECIP      = RECIP_FULL[DVD_W:0];

   logic [DVD_W-1:0]  mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [DIV_QB-1:0] q_ff, q_in;
   logic [RW-1:0]     rm_ff, rm_in;
   logic              mul_ff;
   logic              sub_ff;
   logic              done_ff, done_in;
   logic [NUM_W-1:0]  mag;
   logic [PW-1:0]     prod;
   logic [DVD_W-1:0]  rm_full;
   logic              fix;
   logic signed [QUO_W-1:0] qmag;

   assign mag     = num[NUM_W-1] ? -num : num;
   assign prod    = PW'(mag_ff) * PW'(RECIP);
   assign rm_full = mag_ff - DVD_W'(q_ff) * DVD_W'(DEN);

   // Capture the magnitude, then the quotient, then the remainder, one stage a cycle.
   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      done_in = done_ff;
      q_in    = DIV_QB'(prod >> SH);
      rm_in   = rm_full[RW-1:0];
      if (start) begin
         mag_in  = mag[DVD_W-1:0];
         neg_in  = num[NUM_W-1];
         done_in = 1'b0;
      end else if (sub_ff) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
      rm_ff  <= rm_in;
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= start;
         sub_ff  <= mul_ff;
         done_ff <= done_in;
      end
   end

   // Turn the magnitude result into a floor quotient with a non-negative remainder.
   assign fix  = neg_ff && (rm_ff != '0);
   assign qmag = {1'b0, q_ff};
   assign quo  = neg_ff ? (fix ? ~qmag : -qmag) : qmag;
   assign rem  = fix ? RW'(DEN) - rm_ff : rm_ff;
   assign done = done_ff;

endmodule

// ----- rtl/cbps_back.sv -----
// Back end: per segment setup and forward-difference sample generation.
`include "cubic_bezier_polyline_sampler_unit_defines.svh"

module cbps_back import cbps_pkg::*; #(
   parameter int STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   output logic             q_pop,
   input  segment_type      q_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam int DEN   = STEPS * STEPS * STEPS;
   localparam int RW    = $clog2(DEN + 1);
   localparam int KW    = $clog2(STEPS + 1);
   localparam int LANES = 2;
   localparam int DIFFS = 3;
   localparam logic signed [NUM_W-1:0] K_3SS = NUM_W'(3 * STEPS * STEPS);
   localparam logic signed [NUM_W-1:0] K_3S  = NUM_W'(3 * STEPS);
   localparam logic signed [NUM_W-1:0] K_6S  = NUM_W'(6 * STEPS);
   localparam logic signed [NUM_W-1:0] K_6   = NUM_W'(6);
   localparam logic [KW-1:0]           K_LAST = KW'(STEPS);
   localparam logic [RW:0]             DEN_EXT = (RW + 1)'(DEN);

   // Add two values held as floor quotient and remainder.
   function automatic logic [QUO_W+RW-1:0] qr_add(input logic [QUO_W-1:0] qa,
                                                  input logic [RW-1:0]    ra,
                                                  input logic [QUO_W-1:0] qb,
                                                  input logic [RW-1:0]    rb);
      logic [RW:0]    rs;
      logic [QUO_W-1:0] qs;
      rs = {1'b0, ra} + {1'b0, rb};
      qs = qa + qb;
      if (rs >= DEN_EXT) begin
         rs = rs - DEN_EXT;
         qs = qs + QUO_W'(1);
      end
      return {qs, rs[RW-1:0]};
   endfunction

   back_state_type state_ff, state_in;
   back_ctrl_type  ctrl;
   logic           out_free;

   segment_type seg_ff, seg_in;
   logic signed [PT_W-1:0]  pc     [LANES][SEG_PTS];
   logic signed [C1_W-1:0]  c1_ff  [LANES], c1_in [LANES], c1_c [LANES];
   logic signed [C2_W-1:0]  c2_ff  [LANES], c2_in [LANES], c2_c [LANES];
   logic signed [C3_W-1:0]  c3_ff  [LANES], c3_in [LANES], c3_c [LANES];
   logic signed [C3_W-1:0]  t3     [LANES];
   logic signed [NUM_W-1:0] num_ff [LANES][DIFFS], num_in [LANES][DIFFS];
   logic signed [NUM_W-1:0] num_c  [LANES][DIFFS];

   logic signed [QUO_W-1:0] div_q  [LANES][DIFFS];
   logic        [RW-1:0]    div_r  [LANES][DIFFS];
   logic [LANES*DIFFS-1:0]  done_vec;

   logic [QUO_W-1:0] aq_ff [LANES], aq_in [LANES], aq_s [LANES];
   logic [RW-1:0]    ar_ff [LANES], ar_in [LANES], ar_s [LANES];
   logic [QUO_W-1:0] dq_ff [LANES][DIFFS], dq_in [LANES][DIFFS];
   logic [RW-1:0]    dr_ff [LANES][DIFFS], dr_in [LANES][DIFFS];
   logic [QUO_W-1:0] dq_s  [LANES][DIFFS-1];
   logic [RW-1:0]    dr_s  [LANES][DIFFS-1];
   logic signed [PT_W-1:0] tq [LANES];

   logic [KW-1:0] k_ff, k_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) state_in = BK_COEF;
         end
         BK_COEF: state_in = BK_NUM;
         BK_NUM:  state_in = BK_LOAD;
         BK_LOAD: state_in = BK_DIV;
         BK_DIV: begin
            if (&done_vec) state_in = BK_RUN;
         end
         BK_RUN: begin
            if (out_free && k_ff == K_LAST) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         BK_IDLE: ctrl.pop       = !q_status.empty;
         BK_COEF: ctrl.coef_en   = 1'b1;
         BK_NUM:  ctrl.num_en    = 1'b1;
         BK_LOAD: ctrl.start     = 1'b1;
         BK_DIV:  ctrl.load_diff = &done_vec;
         BK_RUN:  ctrl.emit      = out_free;
         default: ctrl = '0;
      endcase
   end

   assign q_pop = ctrl.pop;

   // Polynomial coefficients, difference numerators and the stepping adds.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         for (int i = 0; i < SEG_PTS; i++) begin
            pc[l][i] = (l == 0) ? seg_ff[i].x : seg_ff[i].y;
         end
         c1_c[l] = C1_W'(pc[l][1]) - C1_W'(pc[l][0]);
         c2_c[l] = C2_W'(pc[l][0]) + C2_W'(pc[l][2]) - (C2_W'(pc[l][1]) <<< 1);
         t3[l]   = C3_W'(pc[l][1]) - C3_W'(pc[l][2]);
         c3_c[l] = C3_W'(pc[l][3]) - C3_W'(pc[l][0]) + (t3[l] <<< 1) + t3[l];

         num_c[l][0] = K_3SS * NUM_W'(c1_ff[l]) + K_3S * NUM_W'(c2_ff[l])
                       + NUM_W'(c3_ff[l]);
         num_c[l][1] = K_6S * NUM_W'(c2_ff[l]) + K_6 * NUM_W'(c3_ff[l]);
         num_c[l][2] = K_6 * NUM_W'(c3_ff[l]);

         {aq_s[l], ar_s[l]} = qr_add(aq_ff[l], ar_ff[l], dq_ff[l][0], dr_ff[l][0]);
         for (int j = 0; j < DIFFS - 1; j++) begin
            {dq_s[l][j], dr_s[l][j]} = qr_add(dq_ff[l][j], dr_ff[l][j],
                                              dq_ff[l][j+1], dr_ff[l][j+1]);
         end

         // Round the floor quotient toward zero.
         tq[l] = aq_ff[l][PT_W-1:0] + PT_W'(aq_ff[l][QUO_W-1] && (ar_ff[l] != '0));
      end
   end

   generate
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         for (genvar j = 0; j < DIFFS; j++) begin : g_diff
            cbps_div #(.STEPS(STEPS)) u_div (
               .clock (clock),
               .reset (reset),
               .start (ctrl.start),
               .num   (num_ff[l][j]),
               .done  (done_vec[l*DIFFS+j]),
               .quo   (div_q[l][j]),
               .rem   (div_r[l][j])
            );
         end
      end
   endgenerate

   always_comb begin
      seg_in       = seg_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      c3_in        = c3_ff;
      num_in       = num_ff;
      aq_in        = aq_ff;
      ar_in        = ar_ff;
      dq_in        = dq_ff;
      dr_in        = dr_ff;
      k_in         = k_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.pop) seg_in = q_data;
      if (ctrl.start) k_in = '0;
      if (ctrl.emit) begin
         rsp_in.curve_x     = tq[0];
         rsp_in.curve_y     = tq[1];
         rsp_in.segment_end = (k_ff == K_LAST);
         rsp_valid_in       = 1'b1;
         k_in               = k_ff + KW'(1);
      end
      for (int l = 0; l < LANES; l++) begin
         if (ctrl.coef_en) begin
            c1_in[l] = c1_c[l];
            c2_in[l] = c2_c[l];
            c3_in[l] = c3_c[l];
         end
         if (ctrl.num_en) begin
            num_in[l] = num_c[l];
         end
         if (ctrl.start) begin
            // The first sample is the first control point exactly.
            aq_in[l] = QUO_W'(pc[l][0]);
            ar_in[l] = '0;
         end
         if (ctrl.load_diff) begin
            for (int j = 0; j < DIFFS; j++) begin
               dq_in[l][j] = div_q[l][j];
               dr_in[l][j] = div_r[l][j];
            end
         end
         if (ctrl.emit) begin
            aq_in[l] = aq_s[l];
            ar_in[l] = ar_s[l];
            for (int j = 0; j < DIFFS - 1; j++) begin
               dq_in[l][j] = dq_s[l][j];
               dr_in[l][j] = dr_s[l][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      seg_in_hold: begin
         seg_ff <= seg_in;
         c1_ff  <= c1_in;
         c2_ff  <= c2_in;
         c3_ff  <= c3_in;
         num_ff <= num_in;
         aq_ff  <= aq_in;
         ar_ff  <= ar_in;
         dq_ff  <= dq_in;
         dr_ff  <= dr_in;
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         state_ff     <= BK_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CBPS_ASSERT_IMPLY(a_run_after_div, clock, reset, state_ff == BK_RUN, &done_vec, "sampling started before the divisions finished")
   `CBPS_ASSERT_IMPLY(a_k_in_range, clock, reset, state_ff == BK_RUN, k_ff <= K_LAST, "sample index past the last sample")
   `CBPS_ASSERT_NEXT(a_last_sample, clock, reset, ctrl.emit && k_ff == K_LAST, state_ff == BK_IDLE && rsp_ff.segment_end, "last sample not marked or sampler not idle")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench: random and directed control points against a cycle-free curve predictor.
module tb_top;
   import cbps_pkg::*;

   localparam int     STEPS         = 16;
   localparam longint CUBE_DENOM    = longint'(STEPS) * STEPS * STEPS;
   localparam int     DRAIN_LIMIT   = 50000;
   localparam int     SETTLE_CYCLES = 3 * (STEPS + 30);
   localparam int     HOLD_OFF_LEN  = 400;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct    = 0;
   int recv_idle_pct    = 0;
   int hold_off_request = 0;
   int hold_off_left    = 0;
   int error_count      = 0;
   int points_sent      = 0;

   // Predictor copy of the collected control points
   point_type ctrl_pts [SEG_PTS];
   int        pts_held = 0;
   rsp_type   expected_samples [$];

   cubic_bezier_polyline_sampler_unit #(.STEPS(STEPS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   // Exact Bernstein sum over STEPS^3, truncated toward zero
   function automatic logic signed [PT_W-1:0] bernstein_coord(
      input longint p0, input longint p1, input longint p2, input longint p3, input int k);
      longint m, kk, acc, quo;
      m   = STEPS - k;
      kk  = k;
      acc = m * m * m * p0 + 3 * m * m * kk * p1 + 3 * m * kk * kk * p2 + kk * kk * kk * p3;
      quo = acc / CUBE_DENOM;
      return quo[PT_W-1:0];
   endfunction

   // Store one point; on a finished segment queue all of its samples
   function automatic void collect_point(input req_type item);
      point_type pt;
      rsp_type   sample;
      pt.x = item.point_x;
      pt.y = item.point_y;
      // a start mark or an empty store opens a new polyline
      if (item.first_point || pts_held == 0) begin
         pts_held = 0;
      end
      ctrl_pts[pts_held] = pt;
      pts_held++;
      if (pts_held == SEG_PTS) begin
         for (int k = 0; k <= STEPS; k++) begin
            sample.curve_x = bernstein_coord($signed(ctrl_pts[0].x), $signed(ctrl_pts[1].x),
                                             $signed(ctrl_pts[2].x), $signed(ctrl_pts[3].x), k);
            sample.curve_y = bernstein_coord($signed(ctrl_pts[0].y), $signed(ctrl_pts[1].y),
                                             $signed(ctrl_pts[2].y), $signed(ctrl_pts[3].y), k);
            sample.segment_end = (k == STEPS);
            expected_samples.push_back(sample);
         end
         // the next segment starts at this one's last point
         ctrl_pts[0] = ctrl_pts[SEG_PTS-1];
         pts_held    = 1;
      end
   endfunction

   function automatic logic signed [PT_W-1:0] pick_coord();
      case ($urandom_range(3))
         0: return PT_W'($urandom_range(15) - 8);
         1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         default: return PT_W'($urandom());
      endcase
   endfunction

   // Offer one request and hold it until taken; then idle at random
   task automatic offer_point(input logic signed [PT_W-1:0] x, input logic signed [PT_W-1:0] y,
                              input logic first);
      req_type item;
      item.point_x     = x;
      item.point_y     = y;
      item.first_point = first;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      collect_point(item);
      points_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Drop valid and wait until every expected sample has come or the drain limit is reached
   task automatic wait_for_drain();
      int cycles;
      cycles = 0;
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      while (expected_samples.size() > 0 && cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      if (expected_samples.size() > 0) begin
         $display("%0t: %0d expected samples never arrived", $time, expected_samples.size());
         error_count++;
         expected_samples.delete();
      end
   endtask

   // A plain point on an empty store opens a polyline by itself
   task automatic test_start_on_empty_store();
      offer_point(16'sd10, -16'sd20, 1'b0);
      offer_point(16'sd300, 16'sd40, 1'b0);
      offer_point(-16'sd50, 16'sd600, 1'b0);
      offer_point(16'sd700, -16'sd80, 1'b0);
   endtask

   task automatic test_coordinate_extremes();
      offer_point(16'sh8000, 16'sh7fff, 1'b1);
      offer_point(16'sh7fff, 16'sh8000, 1'b0);
      offer_point(16'sh8000, 16'sh8000, 1'b0);
      offer_point(16'sh7fff, 16'sh7fff, 1'b0);
   endtask

   // Three more points reuse the last point of the previous segment
   task automatic test_segment_continuation();
      offer_point(16'sd0, 16'sd0, 1'b0);
      offer_point(-16'sd1, 16'sd1, 1'b0);
      offer_point(16'sd1, -16'sd1, 1'b0);
   endtask

   // Restart right after a segment and again in the middle of collection
   task automatic test_restart_mark();
      offer_point(16'sd1000, 16'sd2000, 1'b1);
      offer_point(16'sd3000, 16'sd4000, 1'b0);
      offer_point(-16'sd5, -16'sd6, 1'b1);
      offer_point(16'sd7, 16'sd8, 1'b0);
      offer_point(-16'sd9, 16'sd10, 1'b0);
      offer_point(16'sd11, -16'sd12, 1'b0);
   endtask

   // Small negative sums must round toward zero, not down
   task automatic test_truncation_toward_zero();
      offer_point(-16'sd1, -16'sd1, 1'b1);
      offer_point(16'sd0, 16'sd0, 1'b0);
      offer_point(-16'sd1, 16'sd0, 1'b0);
      offer_point(16'sd1, -16'sd1, 1'b0);
   endtask

   // Mostly whole polylines; some cut short, some with stray start marks
   task automatic test_random_polylines(input int n_points);
      int target, pts;
      target = points_sent + n_points;
      while (points_sent < target) begin
         pts = 1 + 3 * $urandom_range(1, 5);
         if ($urandom_range(9) == 0) begin
            pts = $urandom_range(1, pts - 1);
         end
         for (int i = 0; i < pts; i++) begin
            offer_point(pick_coord(), pick_coord(),
                        (i == 0) ? ($urandom_range(7) != 0) : ($urandom_range(24) == 0));
         end
      end
   endtask

   // Hold the output off long enough that the segment queue fills and stalls requests
   task automatic test_output_backpressure();
      send_idle_pct    = 0;
      hold_off_request = HOLD_OFF_LEN;
      offer_point(pick_coord(), pick_coord(), 1'b1);
      repeat (6 * 3) offer_point(pick_coord(), pick_coord(), 1'b0);
      wait_for_drain();
   endtask

   // Receiver: long hold-off when asked, random stall otherwise
   always @(posedge clock) begin
      if (hold_off_request > 0) begin
         hold_off_left    = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Compare each taken sample with the oldest expectation
   always @(posedge clock) begin : check_samples
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample x=%0d y=%0d end=%0b", $time,
                     rsp_data.curve_x, rsp_data.curve_y, rsp_data.segment_end);
            error_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_data.curve_x !== want.curve_x) begin
               $display("%0t: curve_x expected %0d got %0d", $time, want.curve_x,
                        rsp_data.curve_x);
               error_count++;
            end
            if (rsp_data.curve_y !== want.curve_y) begin
               $display("%0t: curve_y expected %0d got %0d", $time, want.curve_y,
                        rsp_data.curve_y);
               error_count++;
            end
            if (rsp_data.segment_end !== want.segment_end) begin
               $display("%0t: segment_end expected %0b got %0b", $time, want.segment_end,
                        rsp_data.segment_end);
               error_count++;
            end
         end
      end
   end

   initial begin
      send_idle_pct = 18;
      recv_idle_pct = 48;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_start_on_empty_store();
      test_coordinate_extremes();
      test_segment_continuation();
      test_restart_mark();
      test_truncation_toward_zero();
      wait_for_drain();

      test_random_polylines(160);
      wait_for_drain();

      send_idle_pct = 48;
      recv_idle_pct = 18;
      test_random_polylines(160);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_polylines(160);
      wait_for_drain();

      test_output_backpressure();

      // watch for stray samples after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
